[design/csp_pkg.sv]
// Shared constants and types for the stack pointer unit.
`default_nettype none

package csp_pkg;

  localparam int ADDR_BITS = 16;
  localparam int MEM_DEPTH = 1 << ADDR_BITS;

  localparam logic [15:0] SP_RESET = 16'hFFFE;
  localparam logic [7:0]  POP_AF_MASK = 8'hF0;

  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 40;
  localparam int M_USER_W = 2;

  typedef logic [2:0] op_t;

  localparam op_t OP_PUSH     = 3'd0;
  localparam op_t OP_POP      = 3'd1;
  localparam op_t OP_POP_AF   = 3'd2;
  localparam op_t OP_STORE_SP = 3'd3;
  localparam op_t OP_LOAD_SP  = 3'd4;
  localparam op_t OP_ADD_SP   = 3'd5;
  localparam op_t OP_LD_HL_SP = 3'd6;

endpackage

`default_nettype wire

[design/cpu_stack_pointer_unit.sv]
// Stack pointer unit: SP register, byte memory and stack instruction sequencer.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | s_tdata: operation, operand_word, offset
//  m_      | out | m_tvalid/m_tready | m_tdata: result_word, flags_byte, sp_value;
//          |     |                   | m_tuser: result_valid, flags_update
//
// Push and store SP write their two bytes in two steps on the single memory port,
// pop and pop AF do two reads and then a finish step for the registered read data,
// the other operations need no memory access; each ends when the output register is free.
// A full output register holds the sequencer in its last step until m_tready.
// Reset sets SP to 0xFFFE and empties the output; memory contents are kept.
`default_nettype none

module cpu_stack_pointer_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // [2:0] operation, [18:3] operand_word, [26:19] offset, [31:27] zero
  input  wire logic [csp_pkg::S_DATA_W-1:0] s_tdata,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // [15:0] result_word, [23:16] flags_byte, [39:24] sp_value
  output logic [csp_pkg::M_DATA_W-1:0]      m_tdata,
  // [0] result_valid, [1] flags_update
  output logic [csp_pkg::M_USER_W-1:0]      m_tuser
);

  import csp_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SECOND = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]  state, state_next;
  logic [15:0] sp, sp_next;

  op_t         op_q;
  logic [15:0] word_q;
  logic [7:0]  off_q;
  logic [7:0]  lo_q;

  logic [7:0]  mem [MEM_DEPTH];
  logic [7:0]  rd_data;
  logic        mem_we, mem_re;
  logic [15:0] mem_addr16;
  logic [7:0]  mem_wdata;

  op_t         cur_op;
  logic [15:0] cur_word;
  logic [7:0]  cur_off;
  logic [15:0] sum;
  logic [4:0]  half_sum;
  logic [8:0]  byte_sum;
  logic [7:0]  flags_calc;

  logic        accept, out_free, out_load;
  logic [15:0] res_word;
  logic        res_valid, res_upd;
  logic [7:0]  res_flags;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign cur_op   = (state == S_IDLE) ? s_tdata[2:0]  : op_q;
  assign cur_word = (state == S_IDLE) ? s_tdata[18:3] : word_q;
  assign cur_off  = (state == S_IDLE) ? s_tdata[26:19] : off_q;

  assign sum        = sp + {{8{cur_off[7]}}, cur_off};
  assign half_sum   = {1'b0, sp[3:0]} + {1'b0, cur_off[3:0]};
  assign byte_sum   = {1'b0, sp[7:0]} + {1'b0, cur_off};
  assign flags_calc = {2'b00, half_sum[4], byte_sum[8], 4'b0000};

  always_comb begin
    res_word  = '0;
    res_valid = 1'b0;
    res_flags = '0;
    res_upd   = 1'b0;
    case (cur_op)
      OP_POP: begin
        res_word  = {rd_data, lo_q};
        res_valid = 1'b1;
      end
      OP_POP_AF: begin
        res_word  = {rd_data, lo_q & POP_AF_MASK};
        res_valid = 1'b1;
      end
      OP_ADD_SP: begin
        res_flags = flags_calc;
        res_upd   = 1'b1;
      end
      OP_LD_HL_SP: begin
        res_word  = sum;
        res_valid = 1'b1;
        res_flags = flags_calc;
        res_upd   = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    sp_next    = sp;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr16 = sp;
    mem_wdata  = '0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          case (cur_op) inside
            OP_PUSH: begin
              mem_we     = 1'b1;
              mem_addr16 = sp - 16'd1;
              mem_wdata  = cur_word[15:8];
              sp_next    = sp - 16'd1;
              state_next = S_SECOND;
            end
            OP_POP, OP_POP_AF: begin
              mem_re     = 1'b1;
              mem_addr16 = sp;
              sp_next    = sp + 16'd1;
              state_next = S_SECOND;
            end
            OP_STORE_SP: begin
              mem_we     = 1'b1;
              mem_addr16 = cur_word;
              mem_wdata  = sp[7:0];
              state_next = S_SECOND;
            end
            default: begin
              if (out_free) begin
                out_load = 1'b1;
                if (cur_op == OP_LOAD_SP) sp_next = cur_word;
                else if (cur_op == OP_ADD_SP) sp_next = sum;
              end else begin
                state_next = S_FINISH;
              end
            end
          endcase
        end
      end
      S_SECOND: begin
        case (op_q) inside
          OP_PUSH: begin
            mem_we     = 1'b1;
            mem_addr16 = sp - 16'd1;
            mem_wdata  = word_q[7:0];
            sp_next    = sp - 16'd1;
            if (out_free) begin
              out_load   = 1'b1;
              state_next = S_IDLE;
            end else begin
              state_next = S_FINISH;
            end
          end
          OP_POP, OP_POP_AF: begin
            mem_re     = 1'b1;
            mem_addr16 = sp;
            sp_next    = sp + 16'd1;
            state_next = S_FINISH;
          end
          OP_STORE_SP: begin
            mem_we     = 1'b1;
            mem_addr16 = word_q + 16'd1;
            mem_wdata  = sp[15:8];
            if (out_free) begin
              out_load   = 1'b1;
              state_next = S_IDLE;
            end else begin
              state_next = S_FINISH;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          if (op_q == OP_LOAD_SP) sp_next = word_q;
          else if (op_q == OP_ADD_SP) sp_next = sum;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr16[ADDR_BITS-1:0]] <= mem_wdata;
    if (mem_re) rd_data <= mem[mem_addr16[ADDR_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= s_tdata[2:0];
      word_q <= s_tdata[18:3];
      off_q  <= s_tdata[26:19];
    end
    if (state == S_SECOND) lo_q <= rd_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp    <= SP_RESET;
    end else begin
      state <= state_next;
      sp    <= sp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {sp_next, res_flags, res_word};
      m_tuser <= {res_upd, res_valid};
    end
  end

endmodule

`default_nettype wire

[design/csp_checker.sv]
// Port-level checks for the stack pointer unit, bound to the top level.
`default_nettype none

module csp_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_tvalid,
  input wire logic                         s_tready,
  input wire logic [csp_pkg::S_DATA_W-1:0] s_tdata,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [csp_pkg::M_DATA_W-1:0] m_tdata,
  input wire logic [csp_pkg::M_USER_W-1:0] m_tuser
);

  import csp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_flags_only_on_update: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tdata[23:16] == 8'h00)
    else $error("flags nonzero without flags update");

  a_word_only_on_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[15:0] == 16'h0000)
    else $error("result word nonzero without result valid");

  a_push_two_cycles: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata[2:0] == OP_PUSH |=> !s_tready)
    else $error("new item taken during second push write");

endmodule

bind cpu_stack_pointer_unit csp_checker u_csp_checker (.*);

`default_nettype wire
